/* sv/e2e_p1_pkg.sv */
`default_nettype none

package e2e_p1_pkg;

	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DATA_ID          = 3'd0,
		REG_ID_MODE          = 3'd1,
		REG_NIBBLE_SELECT    = 3'd2,
		REG_COUNTER_POSITION = 3'd3,
		REG_CRC_POSITION     = 3'd4,
		REG_MAX_DELTA        = 3'd5
	} reg_index_t;

	typedef enum logic [0:0] {
		OP_PROTECT = 1'b0,
		OP_CHECK   = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ID_BOTH      = 2'd0,
		ID_LOW       = 2'd1,
		ID_ALTERNATE = 2'd2,
		ID_NIBBLE    = 2'd3
	} id_mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SOME_LOST = 3'd1,
		ST_WRONG_CRC = 3'd2,
		ST_WRONG_SEQ = 3'd3,
		ST_REPEATED  = 3'd4,
		ST_SYNC      = 3'd5,
		ST_INITIAL   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		SM_VALID   = 2'd0,
		SM_INVALID = 2'd1,
		SM_INIT    = 2'd2,
		SM_NO_DATA = 2'd3
	} sm_state_t;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_XOR_OUT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h1D;

	typedef struct packed {
		logic [7:0] crc_acc;
		logic [7:0] cap_crc;
		logic [3:0] cap_cnt;
	} frame_t;

	typedef struct packed {
		logic [7:0] crc;
		status_t    status;
		sm_state_t  sm;
		logic       err;
	} result_t;

	// One CRC-8 update, most significant bit first.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] x;
		x = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (x[7]) begin
				x = {x[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				x = {x[6:0], 1'b0};
			end
		end
		return x;
	endfunction

endpackage

`default_nettype wire

/* sv/e2e_profile1_protect_check.sv */
// End-to-end profile 1 protect and check, one message byte per beat.
// Input channel: in_valid/in_ready with opcode (0 protect, 1 check),
// data_byte and last_byte. Each accepted beat gives exactly one result beat
// on the output channel out_valid/out_ready: the byte passed on (with the
// counter nibble inserted in protect mode), and on the last byte the final
// CRC, and in check mode the status, state-machine state and error flag.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no message is in flight.
// A result beat appears in the cycle after its input beat is accepted.
// Throughput is one byte per cycle while each result is taken: the whole
// CRC update, data identifier fold and counter classification sit between
// the message state registers and the result register. On a stall the
// result register holds and in_ready drops, so at most one result waits.
// Reset clears configuration to defaults (counter at byte 1, CRC at byte 0,
// max delta 1), the running CRC to 0xFF, the counters and the first-message
// flag, and empties the result register.
`default_nettype none

module e2e_profile1_protect_check
	import e2e_p1_pkg::*;
#(
	parameter int MAX_MESSAGE_BYTES = 256,
	parameter int COUNTER_LIMIT = 14
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   opcode,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   last_byte,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [7:0]             out_byte,
	output logic                        message_done,
	output logic      [7:0]             crc_value,
	output logic      [2:0]             check_status,
	output logic      [1:0]             sm_state,
	output logic                        error_flag,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [15:0]            cfg_data
);

	logic [15:0] data_id_q;
	id_mode_t    id_mode_q;
	logic [1:0]  nibble_select_q;
	logic [7:0]  counter_position_q;
	logic [7:0]  crc_position_q;
	logic [3:0]  max_delta_q;

	logic        fire;
	opcode_t     op;
	logic [3:0]  send_counter;
	logic [7:0]  byte_out;
	frame_t      frame;
	result_t     result;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        done_q;
	result_t     result_q;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign fire = in_valid && in_ready;
	assign op = opcode_t'(opcode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_id_q <= '0;
			id_mode_q <= ID_BOTH;
			nibble_select_q <= '0;
			counter_position_q <= 8'd1;
			crc_position_q <= 8'd0;
			max_delta_q <= 4'd1;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_DATA_ID: data_id_q <= cfg_data;
				REG_ID_MODE: id_mode_q <= id_mode_t'(cfg_data[1:0]);
				REG_NIBBLE_SELECT: nibble_select_q <= cfg_data[1:0];
				REG_COUNTER_POSITION: counter_position_q <= cfg_data[7:0];
				REG_CRC_POSITION: crc_position_q <= cfg_data[7:0];
				REG_MAX_DELTA: max_delta_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	e2e_p1_frame #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_frame (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.opcode          (op),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.send_counter    (send_counter),
		.counter_position(counter_position_q),
		.crc_position    (crc_position_q),
		.out_byte        (byte_out),
		.frame           (frame)
	);

	e2e_p1_check #(
		.COUNTER_LIMIT(COUNTER_LIMIT)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.opcode       (op),
		.last_byte    (last_byte),
		.frame        (frame),
		.data_id      (data_id_q),
		.id_mode      (id_mode_q),
		.nibble_select(nibble_select_q),
		.max_delta    (max_delta_q),
		.send_counter (send_counter),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= byte_out;
			done_q <= last_byte;
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign message_done = done_q;
	assign crc_value = result_q.crc;
	assign check_status = result_q.status;
	assign sm_state = result_q.sm;
	assign error_flag = result_q.err;

endmodule

`default_nettype wire

/* sv/e2e_p1_frame.sv */
`default_nettype none

module e2e_p1_frame
	import e2e_p1_pkg::*;
#(
	parameter int MAX_MESSAGE_BYTES = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire opcode_t    opcode,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic [3:0] send_counter,
	input  wire logic [7:0] counter_position,
	input  wire logic [7:0] crc_position,
	output logic      [7:0] out_byte,
	output frame_t          frame
);

	localparam int IW = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int PW = (IW > 8) ? IW : 8;
	localparam logic [IW-1:0] IDX_MAX = IW'(MAX_MESSAGE_BYTES);

	logic [IW-1:0] byte_index_q;
	logic [7:0]    running_crc_q;
	logic [7:0]    cap_crc_q;
	logic [3:0]    cap_cnt_q;

	logic          in_range;
	logic          at_cnt;
	logic          at_crc;
	logic [7:0]    byte_mod;

	always_comb begin
		in_range = (byte_index_q < IDX_MAX);
		at_cnt = in_range && (PW'(byte_index_q) == PW'(counter_position));
		at_crc = in_range && (PW'(byte_index_q) == PW'(crc_position));
		byte_mod = data_byte;
		if ((opcode == OP_PROTECT) && at_cnt) begin
			byte_mod = {data_byte[7:4], send_counter};
		end
		out_byte = byte_mod;
		frame.cap_cnt = at_cnt ? byte_mod[3:0] : cap_cnt_q;
		frame.cap_crc = at_crc ? byte_mod : cap_crc_q;
		frame.crc_acc = at_crc ? running_crc_q : crc8_step(running_crc_q, byte_mod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			running_crc_q <= CRC_INIT;
			cap_crc_q <= '0;
			cap_cnt_q <= '0;
		end else if (fire) begin
			if (last_byte) begin
				byte_index_q <= '0;
				running_crc_q <= CRC_INIT;
				cap_crc_q <= '0;
				cap_cnt_q <= '0;
			end else begin
				if (in_range) begin
					byte_index_q <= byte_index_q + IW'(1);
				end
				running_crc_q <= frame.crc_acc;
				cap_crc_q <= frame.cap_crc;
				cap_cnt_q <= frame.cap_cnt;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/e2e_p1_check.sv */
`default_nettype none

module e2e_p1_check
	import e2e_p1_pkg::*;
#(
	parameter int COUNTER_LIMIT = 14
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire opcode_t     opcode,
	input  wire logic        last_byte,
	input  wire frame_t      frame,
	input  wire logic [15:0] data_id,
	input  wire id_mode_t    id_mode,
	input  wire logic [1:0]  nibble_select,
	input  wire logic [3:0]  max_delta,
	output logic      [3:0]  send_counter,
	output result_t          result
);

	localparam logic [4:0] MOD_N = 5'(COUNTER_LIMIT + 1);
	localparam logic [3:0] LIMIT = 4'(COUNTER_LIMIT);

	// The last good counter is kept already reduced modulo the counter range.
	logic [3:0] send_counter_q;
	logic [3:0] last_good_q;
	logic       first_seen_q;

	logic [7:0] id_lo;
	logic [7:0] id_hi;
	logic [7:0] fold_byte;
	logic [7:0] crc_one;
	logic [7:0] crc_fold;
	logic [7:0] crc_final;
	logic [4:0] rc5;
	logic [4:0] lg5;
	logic [4:0] delta;
	logic [4:0] rc_mod;
	status_t    status;
	logic       lg_update;
	logic [3:0] lg_next;

	function automatic logic [4:0] mod_n(input logic [3:0] v);
		logic [4:0] r;
		r = {1'b0, v};
		for (int k = 0; k < 8; k++) begin
			if (r >= MOD_N) begin
				r = r - MOD_N;
			end
		end
		return r;
	endfunction

	always_comb begin
		id_lo = data_id[7:0];
		id_hi = data_id[15:8];
		case (id_mode)
			ID_ALTERNATE: fold_byte = frame.cap_cnt[0] ? id_hi : id_lo;
			ID_NIBBLE: begin
				case (nibble_select)
					2'd0: fold_byte = {4'h0, data_id[3:0]};
					2'd1: fold_byte = {4'h0, data_id[7:4]};
					2'd2: fold_byte = {4'h0, data_id[11:8]};
					default: fold_byte = {4'h0, data_id[15:12]};
				endcase
			end
			default: fold_byte = id_lo;
		endcase
		crc_one = crc8_step(frame.crc_acc, fold_byte);
		crc_fold = (id_mode == ID_BOTH) ? crc8_step(crc_one, id_hi) : crc_one;
		crc_final = crc_fold ^ CRC_XOR_OUT;

		rc5 = {1'b0, frame.cap_cnt};
		lg5 = {1'b0, last_good_q};
		rc_mod = mod_n(frame.cap_cnt);
		delta = (rc5 >= lg5) ? (rc5 - lg5) : (rc5 + MOD_N - lg5);

		status = ST_OK;
		lg_update = 1'b0;
		lg_next = frame.cap_cnt;
		if (frame.cap_crc != crc_final) begin
			status = ST_WRONG_CRC;
		end else if (!first_seen_q) begin
			status = ST_INITIAL;
			lg_update = 1'b1;
			lg_next = rc_mod[3:0];
		end else if (frame.cap_cnt > LIMIT) begin
			status = ST_WRONG_SEQ;
		end else if (delta == 5'd0) begin
			status = ST_REPEATED;
		end else begin
			lg_update = 1'b1;
			if (delta == 5'd1) begin
				status = ST_OK;
			end else if (delta <= {1'b0, max_delta}) begin
				status = ST_SOME_LOST;
			end else begin
				status = ST_SYNC;
			end
		end

		result.crc = 8'h00;
		result.status = ST_OK;
		result.sm = SM_VALID;
		result.err = 1'b0;
		if (last_byte) begin
			result.crc = crc_final;
			if (opcode == OP_CHECK) begin
				result.status = status;
				case (status)
					ST_OK, ST_SOME_LOST: result.sm = SM_VALID;
					ST_WRONG_CRC, ST_WRONG_SEQ, ST_REPEATED: begin
						result.sm = SM_INVALID;
						result.err = 1'b1;
					end
					ST_SYNC: result.sm = SM_INIT;
					default: result.sm = SM_NO_DATA;
				endcase
			end
		end
		send_counter = send_counter_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_counter_q <= '0;
			last_good_q <= '0;
			first_seen_q <= 1'b0;
		end else if (fire && last_byte) begin
			if (opcode == OP_PROTECT) begin
				if (send_counter_q >= LIMIT) begin
					send_counter_q <= '0;
				end else begin
					send_counter_q <= send_counter_q + 4'd1;
				end
			end else begin
				if (lg_update) begin
					last_good_q <= lg_next;
				end
				if (status == ST_INITIAL) begin
					first_seen_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire
